### hdl/iw26_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the inverse 2/6 wavelet row synthesis block.
// Depends on nothing; iw26_synth, iw26_resq and the top level import it.
package iw26_pkg;

    // Configuration register indexes.
    localparam logic CFG_ROW_LENGTH = 1'b0;
    localparam logic CFG_CLIP_BITS  = 1'b1;

    // Shortest row the block handles; shorter settings are raised to this.
    localparam logic [15:0] MIN_ROW_LENGTH = 16'd3;

    // Most output pairs that one input item can produce.
    localparam int MAX_RESULTS = 3;

    // One output pair as it leaves the block.
    typedef struct packed {
        logic signed [15:0] even_sample;
        logic signed [15:0] odd_sample;
        logic [15:0]        pair_index;
        logic               row_end;
    } t_result;

    // Everything the synthesis stage needs for one accepted item: the window
    // contents before the item shifts in, the item itself and its position.
    typedef struct packed {
        logic signed [15:0] low_prev1;
        logic signed [15:0] low_prev0;
        logic signed [15:0] high_prev1;
        logic signed [15:0] high_prev0;
        logic signed [15:0] low_coef;
        logic signed [15:0] high_coef;
        logic [15:0]        position;
        logic               closes_row;
    } t_snap;

    // Up to three results of one item, packed from r0 upward in output order.
    typedef struct packed {
        logic [1:0] count;
        t_result    r0;
        t_result    r1;
        t_result    r2;
    } t_burst;

endpackage

### hdl/iw26_synth.sv
`timescale 1ns / 1ps
// Combinational synthesis filter: turns one item snapshot into up to three
// output pairs. Depends on iw26_pkg.
module iw26_synth import iw26_pkg::*; (
    input  t_snap      i_snap,
    input  logic [3:0] i_clip_bits,
    output t_burst     o_burst
);

    // Boundary tap: outer = (11a - 4b + c + 4) >> 3, inner = (5a + 4b - c + 4) >> 3.
    function automatic logic signed [15:0] f_edge_tap(
        input logic signed [15:0] a,
        input logic signed [15:0] b,
        input logic signed [15:0] c,
        input logic               outer
    );
        logic signed [19:0] ax;
        logic signed [19:0] bx;
        logic signed [19:0] cx;
        logic signed [19:0] s;
        ax = 20'(a);
        bx = 20'(b);
        cx = 20'(c);
        if (outer) begin
            s = (ax <<< 3) + (ax <<< 1) + ax - (bx <<< 2) + cx + 20'sd4;
        end else begin
            s = (ax <<< 2) + ax + (bx <<< 2) - cx + 20'sd4;
        end
        return s[18:3];
    endfunction

    // Interior tap: (p - n + 4) >> 3, wrapped to 16 bits.
    function automatic logic signed [15:0] f_mid_tap(
        input logic signed [15:0] p,
        input logic signed [15:0] n
    );
        logic signed [18:0] d;
        d = 19'(p) - 19'(n) + 19'sd4;
        return d[18:3];
    endfunction

    // (t + c + h) >> 1 or (t + c - h) >> 1, wrapped to 16 bits.
    function automatic logic signed [15:0] f_half(
        input logic signed [15:0] t,
        input logic signed [15:0] c,
        input logic signed [15:0] h,
        input logic               sub
    );
        logic signed [17:0] u;
        u = sub ? 18'(t) + 18'(c) - 18'(h) : 18'(t) + 18'(c) + 18'(h);
        return u[16:1];
    endfunction

    function automatic logic signed [15:0] f_clip(
        input logic signed [15:0] v,
        input logic [3:0]         cb
    );
        logic signed [15:0] maxv;
        maxv = 16'((17'd1 << cb) - 17'd1);
        if (cb == 4'd0) begin
            return v;
        end else if (v < 16'sd0) begin
            return 16'sd0;
        end else if (v > maxv) begin
            return maxv;
        end else begin
            return v;
        end
    endfunction

    logic signed [15:0] w_outer0, w_inner0, w_outerN, w_innerN;
    logic signed [15:0] w_te, w_to;
    t_result            w_first, w_mid, w_last;
    logic               w_active, w_first_pos;

    always_comb begin
        w_active    = (i_snap.position >= 16'd2);
        w_first_pos = (i_snap.position == 16'd2);

        // First pair of the row: edge coefficient is low_prev1.
        w_outer0 = f_edge_tap(i_snap.low_prev1, i_snap.low_prev0, i_snap.low_coef, 1'b1);
        w_inner0 = f_edge_tap(i_snap.low_prev1, i_snap.low_prev0, i_snap.low_coef, 1'b0);
        w_first.even_sample = f_clip(f_half(w_outer0, 16'sd0, i_snap.high_prev1, 1'b0),
                                     i_clip_bits);
        w_first.odd_sample  = f_clip(f_half(w_inner0, 16'sd0, i_snap.high_prev1, 1'b1),
                                     i_clip_bits);
        w_first.pair_index  = 16'd0;
        w_first.row_end     = 1'b0;

        // Interior pair centered on low_prev0.
        w_te = f_mid_tap(i_snap.low_prev1, i_snap.low_coef);
        w_to = f_mid_tap(i_snap.low_coef, i_snap.low_prev1);
        w_mid.even_sample = f_clip(f_half(w_te, i_snap.low_prev0, i_snap.high_prev0, 1'b0),
                                   i_clip_bits);
        w_mid.odd_sample  = f_clip(f_half(w_to, i_snap.low_prev0, i_snap.high_prev0, 1'b1),
                                   i_clip_bits);
        w_mid.pair_index  = i_snap.position - 16'd1;
        w_mid.row_end     = 1'b0;

        // Last pair of the row: taps mirrored, inner feeds the even sample.
        w_outerN = f_edge_tap(i_snap.low_coef, i_snap.low_prev0, i_snap.low_prev1, 1'b1);
        w_innerN = f_edge_tap(i_snap.low_coef, i_snap.low_prev0, i_snap.low_prev1, 1'b0);
        w_last.even_sample = f_clip(f_half(w_innerN, 16'sd0, i_snap.high_coef, 1'b0),
                                    i_clip_bits);
        w_last.odd_sample  = f_clip(f_half(w_outerN, 16'sd0, i_snap.high_coef, 1'b1),
                                    i_clip_bits);
        w_last.pair_index  = i_snap.position;
        w_last.row_end     = 1'b1;

        o_burst.r2 = w_last;
        if (w_first_pos) begin
            o_burst.r0 = w_first;
            o_burst.r1 = w_mid;
        end else begin
            o_burst.r0 = w_mid;
            o_burst.r1 = w_last;
        end

        if (!w_active) begin
            o_burst.count = 2'd0;
        end else begin
            o_burst.count = 2'd1 + 2'(w_first_pos) + 2'(i_snap.closes_row);
        end
    end

endmodule

### hdl/iw26_resq.sv
`timescale 1ns / 1ps
// Result queue: takes up to three results per cycle, hands out one per cycle while popped.
// Depends on iw26_pkg.
module iw26_resq import iw26_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_burst                     i_push,
    input  logic                       i_pop,
    output t_result                    o_head,
    output logic                       o_valid,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_result         r_mem [DEPTH];
    logic [AW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic [AW-1:0]   w_wp1, w_wp2;
    logic            w_pop;

    assign w_wp1 = r_wr_ptr + AW'(1);
    assign w_wp2 = r_wr_ptr + AW'(2);
    assign w_pop = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.r0;
        end
        if (i_push.count >= 2'd2) begin
            r_mem[w_wp1] <= i_push.r1;
        end
        if (i_push.count == 2'd3) begin
            r_mem[w_wp2] <= i_push.r2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + AW'(i_push.count);
            r_rd_ptr <= r_rd_ptr + AW'(w_pop);
            r_count  <= r_count + CW'(i_push.count) - CW'(w_pop);
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_count != '0);
    assign o_count = r_count;

endmodule

### hdl/inverse_wavelet_26_row.sv
`timescale 1ns / 1ps
// Inverse 2/6 wavelet row synthesis, one low/high coefficient pair per item.
// Depends on iw26_pkg, iw26_synth and iw26_resq.
//
// Usage: the input stream carries one coefficient pair per item, low_coef in
// tdata[15:0] and high_coef in tdata[31:16]. The output stream carries one
// reconstructed sample pair per item: even_sample, odd_sample and pair_index
// in tdata, with tlast high on the final pair of a row. Configuration writes
// (row_length at index 0, clip_bits at index 1) go through the cfg channel,
// which is always ready; they should only be issued while the block is idle.
//
// Timing: an accepted item is registered with the window state, the taps
// are computed in the next cycle and the results land in the result queue
// at the following edge, from which they go out in order on the output.
// The block accepts one item per cycle while the result queue has room. The
// first two items of a row give no result, the third gives two (three if it
// also ends the row), the last gives two, the others one, so a row of N items
// yields N pairs and the sustained rate is one item a cycle while the receiver
// keeps up. The input stalls only when the result queue (DEPTH entries, a
// power of two of at least 8) could not take the results of the item in the
// input register together with the three results of a worst-case new item;
// a stalled receiver therefore backs up into the input.
// Reset empties the queue and the pipeline, clears the coefficient windows
// and the row position, and sets row_length to 3 and clip_bits to 0.
module inverse_wavelet_26_row import iw26_pkg::*; #(
    parameter int DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Coefficient stream.
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [31:0] i_s_axis_tdata,   // [15:0] low_coef, [31:16] high_coef
    // Sample stream.
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [15:0] even_sample, [31:16] odd_sample,
                                          // [47:32] pair_index
    output logic        o_m_axis_tlast,   // row_end
    // Configuration write channel.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int CW = $clog2(DEPTH + 1);

    // Configuration registers.
    logic [15:0] r_row_length;
    logic [3:0]  r_clip_bits;

    // Sliding windows and row position, updated as each item is accepted.
    logic signed [15:0] r_low0, r_low1, r_high0, r_high1;
    logic [15:0]        r_pos;

    // Input register feeding the synthesis logic.
    logic  r_s1_valid;
    t_snap r_s1;

    logic [15:0] w_len;
    logic        w_closes;
    logic        w_accept;
    t_snap       n_s1;
    t_burst      w_burst;
    t_burst      w_push;
    t_result     w_head;
    logic [CW-1:0] w_count;
    logic [CW:0]   w_load;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_length <= MIN_ROW_LENGTH;
            r_clip_bits  <= 4'd0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_ROW_LENGTH: r_row_length <= i_cfg_data;
                CFG_CLIP_BITS:  r_clip_bits  <= i_cfg_data[3:0];
                default:        r_clip_bits  <= r_clip_bits;
            endcase
        end
    end

    // Short settings are treated as the minimum row length. A position at or
    // past the last slot closes the row, which also covers a length that was
    // lowered in the middle of a row.
    assign w_len    = (r_row_length < MIN_ROW_LENGTH) ? MIN_ROW_LENGTH : r_row_length;
    assign w_closes = (r_pos >= w_len - 16'd1);

    // Leave room for the results of the item in flight, whose count is already
    // known, and for the worst case of the new one.
    assign w_load = {1'b0, w_count} + (CW+1)'(w_push.count) + (CW+1)'(MAX_RESULTS);
    assign o_s_axis_tready = (w_load <= (CW+1)'(DEPTH));
    assign w_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        n_s1.low_prev1  = r_low1;
        n_s1.low_prev0  = r_low0;
        n_s1.high_prev1 = r_high1;
        n_s1.high_prev0 = r_high0;
        n_s1.low_coef   = i_s_axis_tdata[15:0];
        n_s1.high_coef  = i_s_axis_tdata[31:16];
        n_s1.position   = r_pos;
        n_s1.closes_row = w_closes;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low0     <= '0;
            r_low1     <= '0;
            r_high0    <= '0;
            r_high1    <= '0;
            r_pos      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= w_accept;
            if (w_accept) begin
                r_low1  <= r_low0;
                r_low0  <= n_s1.low_coef;
                r_high1 <= r_high0;
                r_high0 <= n_s1.high_coef;
                if (r_pos >= 16'd2 && w_closes) begin
                    r_pos <= '0;
                end else begin
                    r_pos <= r_pos + 16'd1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1 <= n_s1;
        end
    end

    iw26_synth u_synth (
        .i_snap      (r_s1),
        .i_clip_bits (r_clip_bits),
        .o_burst     (w_burst)
    );

    always_comb begin
        w_push = w_burst;
        if (!r_s1_valid) begin
            w_push.count = 2'd0;
        end
    end

    iw26_resq #(.DEPTH(DEPTH)) u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (i_m_axis_tready),
        .o_head  (w_head),
        .o_valid (o_m_axis_tvalid),
        .o_count (w_count)
    );

    assign o_m_axis_tdata = {w_head.pair_index, w_head.odd_sample, w_head.even_sample};
    assign o_m_axis_tlast = w_head.row_end;

endmodule

### hdl/iw26_check.sv
`timescale 1ns / 1ps
// Port-level checker for the inverse 2/6 wavelet row block, bound to the top.
// Depends on nothing but the top level's port names.
module iw26_check (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [47:0] o_m_axis_tdata,
    input logic        o_m_axis_tlast
);

    // Pair index the next output item must carry.
    logic [15:0] r_exp_idx;
    logic        w_out_acc;

    assign w_out_acc = o_m_axis_tvalid && i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_idx <= '0;
        end else if (w_out_acc) begin
            r_exp_idx <= o_m_axis_tlast ? 16'd0 : o_m_axis_tdata[47:32] + 16'd1;
        end
    end

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("stalled output item changed");

    a_index_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc |-> o_m_axis_tdata[47:32] == r_exp_idx)
        else $error("pair index out of sequence");

    a_row_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_acc && o_m_axis_tlast |-> o_m_axis_tdata[47:32] >= 16'd2)
        else $error("row closed before its third pair");

endmodule

bind inverse_wavelet_26_row iw26_check u_iw26_check (.*);
